// ===== rtl/plid_pkg.sv =====
// Package for the positional list block: sizes, codes and transaction types.
// Used by plid_cell, plid_ctrl and positional_list_insert_delete; no dependencies.
`default_nettype none

package plid_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  // compare width: holds count + 1 and any 5-bit position
  localparam int CMP_W    = ((CNT_W > 5) ? CNT_W : 5) + 1;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DELETE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  typedef struct packed {
    logic               mode;
    logic [4:0]         position;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [4:0]         length;
    logic signed [31:0] head_value;
    logic signed [31:0] tail_value;
    logic signed [31:0] removed_value;
  } rsp_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] slot;
    logic [31:0]      value;
  } cell_cmd_t;

  // values collected cell by cell along the chain
  typedef struct packed {
    logic [31:0] tail;
    logic [31:0] removed;
  } chain_t;

endpackage

`default_nettype wire

// ===== rtl/plid_cell.sv =====
// One list slot: holds an entry and shifts it to or from its neighbors.
// Depends on plid_pkg for the command and chain types.
`default_nettype none

module plid_cell
  import plid_pkg::*;
(
  input  wire logic             clk,
  input  wire cell_cmd_t        cmd,
  input  wire logic [IDX_W-1:0] idx,
  input  wire logic [CNT_W-1:0] count,
  input  wire logic [31:0]      left_data,
  input  wire logic [31:0]      right_data,
  input  wire chain_t           chain_in,
  output logic [31:0]           data,
  output chain_t                chain_out
);

  logic hit;
  logic after;
  logic last;

  assign hit   = (cmd.slot == idx);
  assign after = (idx > cmd.slot);
  assign last  = ((CNT_W'(idx) + CNT_W'(1)) == count);

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_INSERT: begin
        if (hit) begin
          data <= cmd.value;
        end else if (after) begin
          data <= left_data;
        end
      end
      OP_DELETE: begin
        // close the gap: take the right neighbor from the deleted slot on
        if (hit || after) begin
          data <= right_data;
        end
      end
      default: ;
    endcase
  end

  assign chain_out.tail    = chain_in.tail | (last ? data : 32'd0);
  assign chain_out.removed = chain_in.removed | (hit ? data : 32'd0);

endmodule

`default_nettype wire

// ===== rtl/plid_ctrl.sv =====
// Request decode, entry count and result registers of the positional list.
// Depends on plid_pkg; drives the command that all plid_cell instances share.
`default_nettype none

module plid_ctrl
  import plid_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire req_t             req,
  input  wire logic [31:0]      head_data,
  input  wire chain_t           chain_end,
  output logic                  busy,
  output logic                  done,
  output cell_cmd_t             cmd,
  output logic [CNT_W-1:0]      count,
  output rsp_t                  rsp
);

  logic             accept;
  logic [CMP_W-1:0] cnt_w;
  logic [CMP_W-1:0] pos_w;
  logic             ins_full;
  logic             ins_bad;
  logic             del_bad;
  status_t          status_next;
  status_t          status;
  logic [31:0]      removed;
  logic [CNT_W-1:0] count_next;

  assign busy   = rst;
  assign accept = start && !busy;

  assign cnt_w    = CMP_W'(count);
  assign pos_w    = CMP_W'(req.position);
  assign ins_full = (count == CNT_W'(CAPACITY));
  assign ins_bad  = (req.position == 5'd0) || (pos_w > cnt_w + CMP_W'(1));
  assign del_bad  = (req.position == 5'd0) || (pos_w > cnt_w) || (cnt_w < CMP_W'(2));

  always_comb begin
    cmd.slot    = IDX_W'(req.position - 5'd1);
    cmd.value   = req.value;
    cmd.op      = OP_HOLD;
    status_next = ST_DONE;
    count_next  = count;
    if (req.mode == MODE_INSERT) begin
      if (ins_full) begin
        status_next = ST_FULL;
      end else if (ins_bad) begin
        status_next = ST_RANGE;
      end else begin
        cmd.op     = accept ? OP_INSERT : OP_HOLD;
        count_next = count + CNT_W'(1);
      end
    end else begin
      if (del_bad) begin
        status_next = ST_RANGE;
      end else begin
        cmd.op     = accept ? OP_DELETE : OP_HOLD;
        count_next = count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        count   <= count_next;
        status  <= status_next;
        removed <= (cmd.op == OP_DELETE) ? chain_end.removed : 32'd0;
      end
    end
  end

  assign rsp.status        = status;
  assign rsp.length        = 5'(count);
  assign rsp.head_value    = (count != '0) ? head_data : 32'd0;
  assign rsp.tail_value    = chain_end.tail;
  assign rsp.removed_value = removed;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("accepted transaction without result strobe");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !accept |=> !done)
    else $error("result strobe without accepted transaction");

  a_error_keeps: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_DONE) |-> $stable(count))
    else $error("failed request changed the list length");

endmodule

`default_nettype wire

// ===== rtl/positional_list_insert_delete.sv =====
// Top level of the positional list: a chain of CAPACITY cells and a controller.
// Depends on plid_pkg, plid_cell and plid_ctrl.
//
//   channel   handshake       payload   direction
//   request   start / busy    req_t     in
//   result    done (strobe)   rsp_t     out
//
// A request accepted at one edge updates every cell at that edge; its result
// is shown with done high during the next cycle. A new request can be taken
// in every cycle, so one transaction per clock is sustained, set by the
// parallel shift of all cells. busy is high only during reset (synchronous,
// active high), which empties the list. The receiver cannot stall.
`default_nettype none

module positional_list_insert_delete
  import plid_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire req_t req,
  output logic      busy,
  output logic      done,
  output rsp_t      rsp
);

  cell_cmd_t        cmd;
  logic [CNT_W-1:0] count;
  logic [31:0]      data  [CAPACITY];
  chain_t           chain [CAPACITY+1];

  assign chain[0] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [31:0] left_data;
    logic [31:0] right_data;

    if (i == 0) begin : g_first
      assign left_data = 32'd0;
    end else begin : g_mid_l
      assign left_data = data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_data = 32'd0;
    end else begin : g_mid_r
      assign right_data = data[i+1];
    end

    plid_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .idx        (IDX_W'(i)),
      .count      (count),
      .left_data  (left_data),
      .right_data (right_data),
      .chain_in   (chain[i]),
      .data       (data[i]),
      .chain_out  (chain[i+1])
    );
  end

  plid_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (req),
    .head_data (data[0]),
    .chain_end (chain[CAPACITY]),
    .busy      (busy),
    .done      (done),
    .cmd       (cmd),
    .count     (count),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

// ===== sim/list_result_checker.sv =====
// Checker for the positional list: watches the request and result channels,
// predicts each result from its own copy of the list and compares field by field.
// Depends on plid_pkg for the transaction types and codes.
`timescale 1ns / 100ps

module list_result_checker
  import plid_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  req_t req,
  input  logic done,
  input  rsp_t rsp,
  output int   errors,
  output int   occupancy,
  output int   pending
);

  logic [31:0] list_mem [CAPACITY];
  int          list_len;
  rsp_t        awaited_results [$];

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns mismatch in %s: got %h expected %h", $time, what, got, want);
    errors++;
  endtask

  // Apply one request to the model list and return the result it should give.
  function automatic rsp_t apply_list_op(req_t r);
    rsp_t res;
    int   i;
    int   slot;
    res        = '0;
    res.status = ST_DONE;
    slot       = int'(r.position) - 1;
    if (r.mode == MODE_INSERT) begin
      // a full list is reported before a bad position
      if (list_len >= CAPACITY) begin
        res.status = ST_FULL;
      end else if (r.position < 1 || r.position > list_len + 1) begin
        res.status = ST_RANGE;
      end else begin
        for (i = list_len; i > slot; i--) list_mem[i] = list_mem[i-1];
        list_mem[slot] = r.value;
        list_len++;
      end
    end else begin
      // the last remaining entry can never be removed
      if (r.position < 1 || r.position > list_len || list_len < 2) begin
        res.status = ST_RANGE;
      end else begin
        res.removed_value = list_mem[slot];
        for (i = slot; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
        list_len--;
      end
    end
    res.length = 5'(list_len);
    if (list_len > 0) begin
      res.head_value = list_mem[0];
      res.tail_value = list_mem[list_len-1];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      list_len = 0;
      awaited_results.delete();
    end else begin
      // retire the result of an earlier transaction before taking a new one
      if (done) begin
        if (awaited_results.size() == 0) begin
          flag_mismatch("unexpected result status", 32'(rsp.status), 32'd0);
        end else begin
          want = awaited_results.pop_front();
          if (rsp.status !== want.status)
            flag_mismatch("status", 32'(rsp.status), 32'(want.status));
          if (rsp.length !== want.length)
            flag_mismatch("length", 32'(rsp.length), 32'(want.length));
          if (rsp.head_value !== want.head_value)
            flag_mismatch("head_value", rsp.head_value, want.head_value);
          if (rsp.tail_value !== want.tail_value)
            flag_mismatch("tail_value", rsp.tail_value, want.tail_value);
          if (rsp.removed_value !== want.removed_value)
            flag_mismatch("removed_value", rsp.removed_value, want.removed_value);
        end
      end
      if (start && !busy) awaited_results.push_back(apply_list_op(req));
    end
    occupancy <= list_len;
    pending   <= awaited_results.size();
  end

endmodule

// ===== sim/positional_list_insert_delete_test.sv =====
// Testbench top for the positional list: clock, reset and request stimulus.
// Depends on plid_pkg, positional_list_insert_delete and list_result_checker.
`timescale 1ns / 100ps

module positional_list_insert_delete_test;
  import plid_pkg::*;

  logic clk;
  logic rst;
  logic start;
  req_t req;
  logic busy;
  logic done;
  rsp_t rsp;
  int   errors;
  int   occupancy;
  int   pending;
  bit   idle_on;

  positional_list_insert_delete i_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
  );

  list_result_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .rsp       (rsp),
    .errors    (errors),
    .occupancy (occupancy),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("FAIL positional_list_insert_delete");
    $finish;
  end

  // Present one request and hold it until the block takes it.
  task automatic send_req(logic mode, logic [4:0] pos, logic [31:0] val);
    int gap;
    gap = idle_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= '{mode, pos, val};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Stop sending and let every outstanding result come back.
  task automatic wait_drained(int max_cycles);
    int n;
    n = 0;
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 && n < max_cycles) begin
      @(posedge clk);
      n++;
    end
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int          ph;
    int          k;
    int          ins_pct;
    logic        m;
    logic [4:0]  p;
    logic [31:0] v;

    rst     = 1'b1;
    start   = 1'b0;
    req     = '0;
    idle_on = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: errors on an empty list, the single-entry rule, head/tail
    send_req(MODE_DELETE, 5'd1, 32'h0);
    send_req(MODE_INSERT, 5'd0, 32'h1234_5678);
    send_req(MODE_INSERT, 5'd2, 32'h1234_5678);
    send_req(MODE_INSERT, 5'd1, 32'h8000_0000);
    send_req(MODE_DELETE, 5'd1, 32'h0);
    send_req(MODE_INSERT, 5'd2, 32'h7fff_ffff);
    send_req(MODE_INSERT, 5'd1, 32'hffff_ffff);
    send_req(MODE_INSERT, 5'd31, 32'h5);
    send_req(MODE_DELETE, 5'd0, 32'h0);
    send_req(MODE_DELETE, 5'd31, 32'hffff_ffff);
    idle_on = 1'b1;
    // fill to capacity, alternating middle and tail
    for (k = 0; k < CAPACITY - 3; k++)
      send_req(MODE_INSERT, (k % 2) ? 5'(k / 2 + 2) : 5'(k + 4),
               (k % 2) ? 32'haaaa_aaaa : 32'h5555_5555);
    send_req(MODE_INSERT, 5'd2, 32'h0);
    // full list: full status wins over a bad position
    send_req(MODE_INSERT, 5'd0, 32'h1);
    send_req(MODE_INSERT, 5'd17, 32'h1);
    send_req(MODE_DELETE, 5'd17, 32'h0);
    send_req(MODE_DELETE, 5'd16, 32'h0);
    send_req(MODE_DELETE, 5'd8, 32'h0);
    send_req(MODE_DELETE, 5'd1, 32'h0);

    // random phases, each leaning toward filling the list, emptying it or neither
    for (ph = 0; ph < 28; ph++) begin
      case ($urandom_range(0, 2))
        0:       ins_pct = 90;
        1:       ins_pct = 50;
        default: ins_pct = 12;
      endcase
      idle_on = ($urandom_range(0, 2) != 0);
      if (ph == 14) wait_drained(200);
      for (k = 0; k < 50; k++) begin
        m = ($urandom_range(0, 99) < ins_pct) ? MODE_INSERT : MODE_DELETE;
        if ($urandom_range(0, 99) < 15)
          p = 5'($urandom_range(0, 31));
        else if (m == MODE_INSERT)
          p = 5'($urandom_range(1, occupancy + 1));
        else
          p = 5'($urandom_range(1, (occupancy > 0) ? occupancy : 1));
        v = pick_value();
        send_req(m, p, v);
      end
    end

    wait_drained(200);
    if (errors == 0 && pending == 0) begin
      $display("PASS positional_list_insert_delete");
    end else begin
      $display("FAIL positional_list_insert_delete");
    end
    $finish;
  end

endmodule
